// ===== rtl/clr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the clipped line rasterizer.
package clr_pkg;

   localparam int DIM_BITS   = 13;
   localparam int COL_BITS   = 12;
   localparam int COLOR_BITS = 32;
   localparam int RGB_BITS   = 24;

   localparam logic [COLOR_BITS-1:0] INVERT_COLOR = 32'hff00_0000;

   typedef enum logic [0:0] {
      CSR_COLUMNS = 1'b0,
      CSR_ROWS    = 1'b1
   } csr_index_type;

   typedef enum logic [0:0] {
      ACT_LOAD = 1'b0,
      ACT_STEP = 1'b1
   } action_type;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_VERT = 3'd1,
      PH_HORZ = 3'd2,
      PH_XMAJ = 3'd3,
      PH_YMAJ = 3'd4
   } phase_type;

   typedef struct packed {
      logic                done;
      logic                invert;
      logic                emit;
      logic [7:0]          blue;
      logic [7:0]          green;
      logic [7:0]          red;
      logic [COL_BITS-1:0] row;
      logic [COL_BITS-1:0] col;
   } rsp_type;

endpackage

// ===== rtl/clipped_line_rasterizer_core.sv =====
`timescale 1ns / 1ps
// Clipped line rasterizer: line load, per-step pixel generation, output skid stage.
//
// req channel: tuser is the action (0 loads a line, 1 asks for one pixel step);
// tdata carries both endpoints and the color word. Every request gives exactly
// one response on the rsp channel: tuser flags a pixel write and invert mode,
// tlast marks that the line has no further steps.
// csr channel: index 0 writes pixmap columns, index 1 pixmap rows; always ready.
// Write it only while no request is outstanding.
//
// Response: registered in the output register, or in the skid entry while the output stalls.
// Throughput: one request per cycle while req_tready is high; all load clipping and the
// Bresenham add-compare update are combinational between the state and output registers.
// Reset: line engine idle, both dimensions 4096 (clamped to MAX_DIM).
// Stall: the output register plus one skid entry absorb results; req_tready
// drops only once the skid entry is occupied, and rises again when the
// receiver takes a response.
module clipped_line_rasterizer_core
   import clr_pkg::*;
#(
   parameter int COORD_BITS = 16,
   parameter int MAX_DIM    = 4096
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // x_start, y_start, x_end, y_end, color, zero fill
   input  logic [((4*COORD_BITS+COLOR_BITS+7)/8)*8-1:0] req_tdata,
   // action
   input  logic                    req_tuser,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // pixel_column, memory_row, red, green, blue
   output logic [47:0]             rsp_tdata,
   // emit, invert_mode
   output logic [1:0]              rsp_tuser,
   // done_res
   output logic                    rsp_tlast,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  csr_index_type           csr_index,
   input  logic [DIM_BITS-1:0]     csr_data
);

   localparam int CB = COORD_BITS;
   localparam int PW = ((CB > 14) ? CB : 14) + 1;
   localparam int EW = PW + 2;
   localparam logic [16:0] MAX_DIM_W = 17'(MAX_DIM);
   localparam logic [DIM_BITS-1:0] DIM_RESET =
      (MAX_DIM < 4096) ? DIM_BITS'(MAX_DIM) : DIM_BITS'(4096);

   logic [DIM_BITS-1:0] cols_ff, rows_ff, csr_dim;

   phase_type               phase_ff, phase_in, load_phase;
   logic signed [PW-1:0]    run_pos_ff, run_pos_in;
   logic signed [PW-1:0]    run_lim_ff, run_lim_in;
   logic signed [PW-1:0]    cross_ff, cross_in;
   logic signed [EW-1:0]    err_ff, err_in;
   logic signed [EW-1:0]    flat_ff, flat_in;
   logic signed [EW-1:0]    diag_ff, diag_in;
   logic                    rising_ff, rising_in;
   logic signed [PW-1:0]    final_x_ff, final_x_in;
   logic signed [PW-1:0]    final_y_ff, final_y_in;
   logic [RGB_BITS-1:0]     paint_rgb_ff, paint_rgb_in;
   logic                    paint_invert_ff, paint_invert_in;

   rsp_type out_ff, skid_ff, res;
   logic    out_valid_ff, skid_valid_ff;
   logic    accept, out_take, is_load, step_done;

   logic signed [PW-1:0] xs, ys, xe, ye, cols_s, rows_s, rows_m1;
   logic signed [PW-1:0] a_s, a_e, a_lo, a_hi, a_lo_c, a_hi_c, other, a_dim, o_dim;
   logic signed [PW-1:0] dx, dy, adx, ady, major, minor;
   logic signed [PW-1:0] px, py, row_p;
   logic signed [EW-1:0] major_e, minor_e;
   logic [COLOR_BITS-1:0] color;
   logic is_vert, axis_ok, x_major, at_end, in_bounds, emit, go_diag;

   assign accept     = req_tvalid && req_tready;
   assign out_take   = out_valid_ff && rsp_tready;
   assign req_tready = !skid_valid_ff;
   assign csr_ready  = 1'b1;
   assign is_load    = (action_type'(req_tuser) == ACT_LOAD);

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.blue, out_ff.green, out_ff.red, out_ff.row, out_ff.col};
   assign rsp_tuser  = {out_ff.invert, out_ff.emit};
   assign rsp_tlast  = out_ff.done;

   // dimensions are stored already clamped to 1..MAX_DIM
   always_comb begin
      if (csr_data == '0) begin
         csr_dim = DIM_BITS'(1);
      end else if ({4'b0, csr_data} > MAX_DIM_W) begin
         csr_dim = DIM_BITS'(MAX_DIM);
      end else begin
         csr_dim = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= DIM_RESET;
         rows_ff <= DIM_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_COLUMNS: cols_ff <= csr_dim;
            CSR_ROWS:    rows_ff <= csr_dim;
         endcase
      end
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         if (is_load) begin
            phase_in = load_phase;
         end else if (phase_ff != PH_IDLE && step_done) begin
            phase_in = PH_IDLE;
         end
      end
   end

   // load decode, step update and response
   always_comb begin
      xs    = {{(PW-CB){req_tdata[CB-1]}},   req_tdata[0*CB +: CB]};
      ys    = {{(PW-CB){req_tdata[2*CB-1]}}, req_tdata[1*CB +: CB]};
      xe    = {{(PW-CB){req_tdata[3*CB-1]}}, req_tdata[2*CB +: CB]};
      ye    = {{(PW-CB){req_tdata[4*CB-1]}}, req_tdata[3*CB +: CB]};
      color = req_tdata[4*CB +: COLOR_BITS];

      cols_s  = $signed({{(PW-DIM_BITS){1'b0}}, cols_ff});
      rows_s  = $signed({{(PW-DIM_BITS){1'b0}}, rows_ff});
      rows_m1 = rows_s - PW'(1);

      // axis line: clip the run along its axis
      is_vert = (xs == xe);
      a_s     = is_vert ? ys : xs;
      a_e     = is_vert ? ye : xe;
      other   = is_vert ? xs : ys;
      a_dim   = is_vert ? rows_s : cols_s;
      o_dim   = is_vert ? cols_s : rows_s;
      a_lo    = (a_s < a_e) ? a_s : a_e;
      a_hi    = (a_s < a_e) ? a_e : a_s;
      axis_ok = (other >= 0) && (other < o_dim) && (a_lo < a_dim) && (a_hi >= 0);
      a_lo_c  = (a_lo < 0) ? '0 : a_lo;
      a_hi_c  = (a_hi >= a_dim) ? (a_dim - PW'(1)) : a_hi;

      // sloped line setup
      dx      = xe - xs;
      dy      = ye - ys;
      adx     = dx[PW-1] ? -dx : dx;
      ady     = dy[PW-1] ? -dy : dy;
      x_major = adx > ady;
      major   = x_major ? adx : ady;
      minor   = x_major ? ady : adx;
      major_e = {{2{major[PW-1]}}, major};
      minor_e = {{2{minor[PW-1]}}, minor};

      // step
      step_done = run_pos_ff >= run_lim_ff;
      px     = (phase_ff == PH_XMAJ) ? run_pos_ff : cross_ff;
      py     = (phase_ff == PH_XMAJ) ? cross_ff : run_pos_ff;
      row_p  = rows_m1 - py;
      at_end = (px == final_x_ff) && (py == final_y_ff);
      in_bounds = (px >= 0) && (px < cols_s) && (py >= 0) && (py < rows_s);
      go_diag = rising_ff ? !err_ff[EW-1] : (!err_ff[EW-1] && (err_ff != '0));

      load_phase      = PH_IDLE;
      run_pos_in      = run_pos_ff;
      run_lim_in      = run_lim_ff;
      cross_in        = cross_ff;
      err_in          = err_ff;
      flat_in         = flat_ff;
      diag_in         = diag_ff;
      rising_in       = rising_ff;
      final_x_in      = final_x_ff;
      final_y_in      = final_y_ff;
      paint_rgb_in    = paint_rgb_ff;
      paint_invert_in = paint_invert_ff;
      emit            = 1'b0;
      res             = '0;

      if (is_load) begin
         paint_invert_in = (color == INVERT_COLOR);
         paint_rgb_in    = color[RGB_BITS-1:0];
         final_x_in      = xe;
         final_y_in      = ye;
         if (is_vert || (ys == ye)) begin
            if (axis_ok) begin
               load_phase = is_vert ? PH_VERT : PH_HORZ;
               if (is_vert) begin
                  run_pos_in = rows_m1 - a_hi_c;
                  run_lim_in = rows_m1 - a_lo_c;
                  cross_in   = xs;
               end else begin
                  run_pos_in = a_lo_c;
                  run_lim_in = a_hi_c;
                  cross_in   = rows_m1 - ys;
               end
            end
         end else begin
            rising_in = (dx > 0) == (dy > 0);
            if (x_major) begin
               load_phase = PH_XMAJ;
               run_pos_in = dx[PW-1] ? xe : xs;
               cross_in   = dx[PW-1] ? ye : ys;
               run_lim_in = dx[PW-1] ? xs : xe;
            end else begin
               load_phase = PH_YMAJ;
               run_pos_in = dy[PW-1] ? ye : ys;
               cross_in   = dy[PW-1] ? xe : xs;
               run_lim_in = dy[PW-1] ? ys : ye;
            end
            flat_in = minor_e <<< 1;
            err_in  = (minor_e <<< 1) - major_e;
            diag_in = (minor_e - major_e) <<< 1;
         end
         res.done = (load_phase == PH_IDLE);
      end else if (phase_ff == PH_IDLE) begin
         res.done = 1'b1;
      end else begin
         res.done = step_done;
         case (phase_ff)
            PH_VERT: begin
               emit    = 1'b1;
               res.col = COL_BITS'(cross_ff);
               res.row = COL_BITS'(run_pos_ff);
            end
            PH_HORZ: begin
               emit    = 1'b1;
               res.col = COL_BITS'(run_pos_ff);
               res.row = COL_BITS'(cross_ff);
            end
            default: begin
               emit = !at_end && in_bounds;
               if (emit) begin
                  res.col = COL_BITS'(px);
                  res.row = COL_BITS'(row_p);
               end
               if (go_diag) begin
                  cross_in = rising_ff ? (cross_ff + PW'(1)) : (cross_ff - PW'(1));
                  err_in   = err_ff + diag_ff;
               end else begin
                  err_in   = err_ff + flat_ff;
               end
            end
         endcase
         if (!step_done) begin
            run_pos_in = run_pos_ff + PW'(1);
         end
         res.emit = emit;
         if (emit) begin
            res.invert = paint_invert_ff;
            res.red    = paint_rgb_ff[23:16];
            res.green  = paint_rgb_ff[15:8];
            res.blue   = paint_rgb_ff[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         run_pos_ff      <= run_pos_in;
         run_lim_ff      <= run_lim_in;
         cross_ff        <= cross_in;
         err_ff          <= err_in;
         flat_ff         <= flat_in;
         diag_ff         <= diag_in;
         rising_ff       <= rising_in;
         final_x_ff      <= final_x_in;
         final_y_ff      <= final_y_in;
         paint_rgb_ff    <= paint_rgb_in;
         paint_invert_ff <= paint_invert_in;
      end
   end

   // output register with one skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (accept) begin
         if (!out_valid_ff || out_take) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (out_take) begin
         if (skid_valid_ff) begin
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         if (!out_valid_ff || out_take) begin
            out_ff <= res;
         end else begin
            skid_ff <= res;
         end
      end else if (out_take && skid_valid_ff) begin
         out_ff <= skid_ff;
      end
   end

endmodule
